// File: hdl/cv3_pkg.sv
package cv3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int KSIZE    = 3;
    localparam int TAPS     = KSIZE * KSIZE;
    localparam int CHANNELS = 3;
    localparam int MIN_DIM  = 3;

    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int ROW_W   = KSIZE * COEF_W;
    localparam int FW_W    = 11;
    localparam int FH_W    = 13;
    localparam int CFG_IDX_W = 3;

    // q8.8 arithmetic widths
    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int PART_W = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 3;

    localparam int OFFSET_Q  = 127 * 256;
    localparam int CLAMP_MAX = 255;
    localparam int SAT_HI_Q  = CLAMP_MAX * 256;

    localparam logic [ROW_W-1:0] KERN_TOP_RST = '0;
    localparam logic [ROW_W-1:0] KERN_MID_RST = 48'h0000_0100_0000;
    localparam logic [ROW_W-1:0] KERN_BOT_RST = '0;
    localparam logic [FW_W-1:0]  FW_RST       = 11'd1024;
    localparam logic [FH_W-1:0]  FH_RST       = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERN_TOP    = 3'd0,
        CFG_KERN_MIDDLE = 3'd1,
        CFG_KERN_BOTTOM = 3'd2,
        CFG_ADD_OFFSET  = 3'd3,
        CFG_FRAME_WIDTH = 3'd4,
        CFG_FRAME_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef t_pixel [KSIZE-1:0][KSIZE-1:0] t_window;

    typedef struct packed {
        t_pixel upper;
        t_pixel middle;
    } t_line_entry;

    typedef logic [TAPS-1:0][PIX_W-1:0]  t_tap_arr;
    typedef logic [TAPS-1:0][COEF_W-1:0] t_coef_arr;

    typedef struct packed {
        logic c;
        logic d;
        logic e;
    } t_stage_en;

endpackage

// File: hdl/cv3_if.sv
interface cv3_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [cv3_pkg::PIX_W-1:0] pixel_blue;
    logic [cv3_pkg::PIX_W-1:0] pixel_green;
    logic [cv3_pkg::PIX_W-1:0] pixel_red;

    modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
    modport sink   (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

interface cv3_result_if;
    logic                      valid;
    logic                      ready;
    logic [cv3_pkg::PIX_W-1:0] out_blue;
    logic [cv3_pkg::PIX_W-1:0] out_green;
    logic [cv3_pkg::PIX_W-1:0] out_red;
    logic                      end_of_frame;

    modport source (output valid, out_blue, out_green, out_red, end_of_frame, input ready);
    modport sink   (input valid, out_blue, out_green, out_red, end_of_frame, output ready);
endinterface

interface cv3_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cv3_pkg::CFG_IDX_W-1:0] index;
    logic [cv3_pkg::ROW_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/convolution_3x3_offset_clamp.sv
// 3x3 convolution on an rgb888 raster stream, with optional +127 offset and
// a clamp to 0..255.
// i_pix takes one pixel per item in raster order; o_res gives one item for
// each interior pixel, that is for every input at row >= 2 and column >= 2;
// border pixels are not sent and the receiver fills them. end_of_frame marks
// the result of the last input of the frame.
// i_cfg writes the kernel rows, the offset enable and the frame size; it is
// always ready and should only be used while the stream is idle.
// throughput: one item per cycle while the receiver is ready. a result is
// registered through the line-store read, window shift, products, partial
// sums and clamp register after the input that completes its window.
// each of the three colour lanes has nine 9x16 multipliers, one partial-sum
// stage and a sum/clamp stage feeding the output register.
// a stalled receiver stops the output register; stages behind it keep taking
// items until every stage is full, so at most five items are held.
// reset clears counters and stage valids, sets config registers to defaults;
// the line store is not cleared, a frame refills it in its first two rows.
module convolution_3x3_offset_clamp #(
    parameter int MAX_WIDTH  = cv3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cv3_pkg::DEF_MAX_HEIGHT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cv3_pixel_if.sink    i_pix,
    cv3_result_if.source o_res,
    cv3_cfg_if.sink      i_cfg
);
    import cv3_pkg::*;

    logic [ROW_W-1:0] r_kern [KSIZE];
    logic             r_add_offset;
    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;

    logic    win_valid;
    t_window win;
    logic    win_eof;
    t_pixel  in_pixel;

    logic      r_v_c, r_v_d, r_v_e;
    logic      r_eof_c, r_eof_d, r_eof_e;
    t_stage_en en;

    t_tap_arr  taps [CHANNELS];
    t_coef_arr coefs;
    logic [PIX_W-1:0] lane_val [CHANNELS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kern[0]      <= KERN_TOP_RST;
            r_kern[1]      <= KERN_MID_RST;
            r_kern[2]      <= KERN_BOT_RST;
            r_add_offset   <= 1'b0;
            r_frame_width  <= FW_RST;
            r_frame_height <= FH_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_KERN_TOP:     r_kern[0]      <= i_cfg.data;
                CFG_KERN_MIDDLE:  r_kern[1]      <= i_cfg.data;
                CFG_KERN_BOTTOM:  r_kern[2]      <= i_cfg.data;
                CFG_ADD_OFFSET:   r_add_offset   <= i_cfg.data[0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg.data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_pixel = '{red: i_pix.pixel_red, green: i_pix.pixel_green,
                        blue: i_pix.pixel_blue};

    cv3_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_valid        (i_pix.valid),
        .o_ready        (i_pix.ready),
        .i_pixel        (in_pixel),
        .i_take         (en.c),
        .o_valid        (win_valid),
        .o_win          (win),
        .o_eof          (win_eof)
    );

    // each stage loads when empty or when the one after it moves on
    always_comb begin
        en.e = !r_v_e || o_res.ready;
        en.d = !r_v_d || en.e;
        en.c = !r_v_c || en.d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_c <= 1'b0;
            r_v_d <= 1'b0;
            r_v_e <= 1'b0;
        end else begin
            if (en.c) r_v_c <= win_valid;
            if (en.d) r_v_d <= r_v_c;
            if (en.e) r_v_e <= r_v_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.c) r_eof_c <= win_eof;
        if (en.d) r_eof_d <= r_eof_c;
        if (en.e) r_eof_e <= r_eof_d;
    end

    // kernel is applied unflipped: left coefficient meets the oldest column
    always_comb begin
        for (int m = 0; m < KSIZE; m++) begin
            for (int n = 0; n < KSIZE; n++) begin
                coefs[KSIZE*m+n]   = r_kern[m][COEF_W*n +: COEF_W];
                taps[0][KSIZE*m+n] = win[m][n].blue;
                taps[1][KSIZE*m+n] = win[m][n].green;
                taps[2][KSIZE*m+n] = win[m][n].red;
            end
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        cv3_lane u_lane (
            .i_clk        (i_clk),
            .i_en         (en),
            .i_taps       (taps[g]),
            .i_coefs      (coefs),
            .i_add_offset (r_add_offset),
            .o_value      (lane_val[g])
        );
    end

    // merge the lanes into one result item
    assign o_res.valid        = r_v_e;
    assign o_res.out_blue     = lane_val[0];
    assign o_res.out_green    = lane_val[1];
    assign o_res.out_red      = lane_val[2];
    assign o_res.end_of_frame = r_eof_e;

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v_e |-> i_pix.ready)
        else $error("input stalled with empty output register");

    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result valid straight after reset");

    a_output_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !r_v_d) |=> !o_res.valid)
        else $error("result item repeated");

endmodule

// File: hdl/cv3_window.sv
module cv3_window #(
    parameter int MAX_WIDTH  = cv3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cv3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [cv3_pkg::FW_W-1:0]   i_frame_width,
    input  logic [cv3_pkg::FH_W-1:0]   i_frame_height,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  cv3_pkg::t_pixel            i_pixel,
    input  logic                       i_take,
    output logic                       o_valid,
    output cv3_pkg::t_window           o_win,
    output logic                       o_eof
);
    import cv3_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int LWW = ((CW > FW_W) ? CW : FW_W) + 1;
    localparam int LWH = ((RW > FH_W) ? RW : FH_W) + 1;

    // line store: two previous rows side by side
    t_line_entry r_line [MAX_WIDTH];
    t_line_entry r_rd;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic          r_v_a;
    t_pixel        r_pix_a;
    logic [CW-1:0] r_col_a;
    logic          r_emit_a;
    logic          r_eof_a;
    logic          r_wr_pend;

    logic    r_v_b;
    t_window r_win;
    logic    r_eof_b;

    logic ld_b, xfer_a, accept;
    logic last_col, last_row, emit;
    logic [LWW-1:0] fw_ext, c_ext;
    logic [LWH-1:0] fh_ext, r_ext;

    assign ld_b    = !r_v_b || i_take;
    assign xfer_a  = r_v_a && ld_b;
    assign o_ready = !r_v_a || ld_b;
    assign accept  = i_valid && o_ready;

    always_comb begin
        fw_ext = LWW'(i_frame_width);
        c_ext  = LWW'(r_col);
        fh_ext = LWH'(i_frame_height);
        r_ext  = LWH'(r_row);
        // size below three counts as three, above the store size as the store size
        if (fw_ext < LWW'(MIN_DIM)) begin
            last_col = c_ext >= LWW'(MIN_DIM - 1);
        end else begin
            last_col = (c_ext + LWW'(1) >= fw_ext) || (c_ext == LWW'(MAX_WIDTH - 1));
        end
        if (fh_ext < LWH'(MIN_DIM)) begin
            last_row = r_ext >= LWH'(MIN_DIM - 1);
        end else begin
            last_row = (r_ext + LWH'(1) >= fh_ext) || (r_ext == LWH'(MAX_HEIGHT - 1));
        end
        emit = (r_ext >= LWH'(MIN_DIM - 1)) && (c_ext >= LWW'(MIN_DIM - 1));
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_v_a     <= 1'b0;
            r_wr_pend <= 1'b0;
            r_v_b     <= 1'b0;
        end else begin
            r_wr_pend <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (o_ready) begin
                r_v_a <= i_valid;
            end
            if (ld_b) begin
                r_v_b <= r_v_a && r_emit_a;
            end
        end
    end

    // read at accept, write back in the following cycle from the registered read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line[r_col];
        end
        if (r_wr_pend) begin
            r_line[r_col_a] <= '{upper: r_rd.middle, middle: r_pix_a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix_a  <= i_pixel;
            r_col_a  <= r_col;
            r_emit_a <= emit;
            r_eof_a  <= last_col && last_row;
        end
        if (xfer_a) begin
            for (int m = 0; m < KSIZE; m++) begin
                r_win[m][0] <= r_win[m][1];
                r_win[m][1] <= r_win[m][2];
            end
            r_win[0][2] <= r_rd.upper;
            r_win[1][2] <= r_rd.middle;
            r_win[2][2] <= r_pix_a;
            r_eof_b     <= r_eof_a;
        end
    end

    assign o_valid = r_v_b;
    assign o_win   = r_win;
    assign o_eof   = r_eof_b;

endmodule

// File: hdl/cv3_lane.sv
module cv3_lane (
    input  logic                     i_clk,
    input  cv3_pkg::t_stage_en       i_en,
    input  cv3_pkg::t_tap_arr        i_taps,
    input  cv3_pkg::t_coef_arr       i_coefs,
    input  logic                     i_add_offset,
    output logic [cv3_pkg::PIX_W-1:0] o_value
);
    import cv3_pkg::*;

    logic signed [PROD_W-1:0] r_prod [TAPS];
    logic signed [PART_W-1:0] r_part [KSIZE];
    logic        [PIX_W-1:0]  r_value;
    logic signed [SUM_W-1:0]  n_sum;

    always_comb begin
        n_sum = i_add_offset ? SUM_W'(OFFSET_Q) : '0;
        for (int m = 0; m < KSIZE; m++) begin
            n_sum = n_sum + SUM_W'(r_part[m]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.c) begin
            for (int k = 0; k < TAPS; k++) begin
                r_prod[k] <= $signed({1'b0, i_taps[k]}) * $signed(i_coefs[k]);
            end
        end
        if (i_en.d) begin
            for (int m = 0; m < KSIZE; m++) begin
                r_part[m] <= PART_W'(r_prod[3*m]) + PART_W'(r_prod[3*m+1])
                           + PART_W'(r_prod[3*m+2]);
            end
        end
        if (i_en.e) begin
            if (n_sum > $signed(SUM_W'(SAT_HI_Q))) begin
                r_value <= PIX_W'(CLAMP_MAX);
            end else if (n_sum < 0) begin
                r_value <= '0;
            end else begin
                r_value <= n_sum[15:8];
            end
        end
    end

    assign o_value = r_value;

endmodule
